// ----- src/rational_arithmetic_unit_assert.svh -----
// Assertion macros for the rational arithmetic unit checker.
// Included by the checker module; holds only macro definitions.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// Implication checked at every posedge of clk outside reset.
`define RAU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rational unit check failed");

// Next-cycle implication checked outside reset.
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rational unit check failed");

`endif

// ----- src/rau_pkg.sv -----
// Package for the rational arithmetic unit: payload structs and op codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;
  localparam int OpW = 16;
  localparam int NumW = 33;
  localparam int DenW = 31;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  typedef struct packed {
    logic [1:0] opcode;
    logic signed [OpW-1:0] a_numerator;
    logic signed [OpW-1:0] a_denominator;
    logic signed [OpW-1:0] b_numerator;
    logic signed [OpW-1:0] b_denominator;
  } rau_in_t;

  typedef struct packed {
    logic signed [NumW-1:0] result_numerator;
    logic [DenW-1:0] result_denominator;
    logic status;
  } rau_out_t;
endpackage
`default_nettype wire

// ----- src/rational_arithmetic_unit.sv -----
// Rational arithmetic unit: add, subtract, multiply or divide two fractions,
// reduced by a GCD that shares a subtractor with division. Uses rau_pkg.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries opcode and two fractions.
//   Output channel out_valid/out_stall/out_data carries the reduced fraction
//   and a status bit (1 on zero denominator, result 0/0).
//   in_stall is high while an item is in work; one transaction is handled
//   at a time. Steps: the multiply states S_MUL1 and S_MUL2 and the combine
//   state S_COMB, then a binary GCD on 33-bit magnitudes (one subtract or
//   shift per cycle), then two restoring divisions by the GCD at one
//   quotient bit per cycle, then the output state. A zero denominator or a
//   zero numerator goes from the GCD state straight to the output state,
//   skipping the divisions. The result sits in an output register until
//   out_stall is low. The next item may be accepted meanwhile, but its
//   result waits in the output state until the register has emptied.
//   Synchronous active low reset returns the sequencer to idle and drops
//   out_valid.
`timescale 1ns / 1ps
`default_nettype none
module rational_arithmetic_unit
  import rau_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire rau_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output rau_out_t      out_data
);
  localparam int OPERAND_WIDTH = OpW;
  localparam int MW = 2 * OPERAND_WIDTH + 1;   // magnitude width
  localparam int CW = $clog2(MW + 1);
  localparam int SW = $clog2(MW + 1);

  localparam logic [3:0] S_IDLE = 4'd0, S_MUL1 = 4'd1, S_MUL2 = 4'd2, S_COMB = 4'd3,
                         S_GCD = 4'd4, S_DIVN = 4'd5, S_DIVD = 4'd6, S_OUT = 4'd7;

  logic [3:0] st_r, st_nxt;
  logic [1:0] op_r;
  logic [OPERAND_WIDTH-1:0] an_r, ad_r, bn_r, bd_r;  // magnitudes
  logic ans_r, ads_r, bns_r, bds_r;
  logic [MW-1:0] p1_r, p2_r, n_r, d_r;                 // products, num, den
  logic p1s_r, p2s_r, ns_r, ds_r;
  logic [MW-1:0] x_r, y_r;                               // gcd working pair
  logic [SW-1:0] k_r;                                   // common power of two
  logic [MW-1:0] g_r;                                   // gcd
  logic [MW-1:0] q_r, rem_r;
  logic [CW-1:0] cnt_r;
  logic [MW-1:0] qn_r;
  rau_out_t res_r;
  logic ov_r;

  // Magnitude of a two's-complement operand field.
  function automatic logic [OPERAND_WIDTH-1:0] mag_of(input logic [OPERAND_WIDTH-1:0] v);
    mag_of = v[OPERAND_WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

  assign in_stall = (st_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_data = res_r;

  // Shared multiplier operand selection.
  logic [OPERAND_WIDTH-1:0] mx, my;
  logic [MW-1:0] prod;
  always_comb begin
    mx = an_r; my = bd_r;
    if (st_r == S_MUL1) begin
      case (op_r)
        OP_MUL:  begin mx = an_r; my = bn_r; end
        default: begin mx = an_r; my = bd_r; end
      endcase
    end else begin
      case (op_r)
        OP_DIV:  begin mx = ad_r; my = bn_r; end
        default: begin mx = bn_r; my = ad_r; end
      endcase
    end
    prod = MW'(mx) * MW'(my);
  end

  // Shared subtractor used by the GCD and both divisions.
  logic [MW-1:0] sa, sb, sdiff;
  logic [MW:0] trial;
  logic [MW:0] rsh;
  always_comb begin
    rsh = {rem_r, q_r[MW-1]};
    sa = x_r; sb = y_r;
    if (st_r == S_DIVN || st_r == S_DIVD) begin
      sa = rsh[MW-1:0]; sb = g_r;
    end
    trial = {1'b0, sa} - {1'b0, sb};
    sdiff = trial[MW-1:0];
  end
  logic dge;
  assign dge = rsh[MW] || !trial[MW];

  logic [MW-1:0] sum_ext;
  logic p2neg;
  always_comb begin
    p2neg = (op_r == OP_SUB) ? ((p2_r != '0) && !p2s_r) : p2s_r;
    if (p1s_r == p2neg) sum_ext = p1_r + p2_r;
    else if (p1_r >= p2_r) sum_ext = p1_r - p2_r;
    else sum_ext = p2_r - p1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_OUT && !ov_r) ov_r <= 1'b1;
      else if (ov_r && !out_stall) ov_r <= 1'b0;
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (in_valid) st_nxt = S_MUL1;
      S_MUL1: st_nxt = S_MUL2;
      S_MUL2: st_nxt = S_COMB;
      S_COMB: st_nxt = S_GCD;
      S_GCD: begin
        if (d_r == '0 || n_r == '0) st_nxt = S_OUT;
        else if (y_r == '0) st_nxt = S_DIVN;
      end
      S_DIVN: if (cnt_r == CW'(MW - 1)) st_nxt = S_DIVD;
      S_DIVD: if (cnt_r == CW'(MW - 1)) st_nxt = S_OUT;
      S_OUT: if (!ov_r) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        op_r <= in_data.opcode;
        an_r <= mag_of(in_data.a_numerator[OPERAND_WIDTH-1:0]);
        ad_r <= mag_of(in_data.a_denominator[OPERAND_WIDTH-1:0]);
        bn_r <= mag_of(in_data.b_numerator[OPERAND_WIDTH-1:0]);
        bd_r <= mag_of(in_data.b_denominator[OPERAND_WIDTH-1:0]);
        ans_r <= in_data.a_numerator[OPERAND_WIDTH-1];
        ads_r <= in_data.a_denominator[OPERAND_WIDTH-1];
        bns_r <= in_data.b_numerator[OPERAND_WIDTH-1];
        bds_r <= in_data.b_denominator[OPERAND_WIDTH-1];
      end
      S_MUL1: begin
        p1_r <= prod;
        p1s_r <= (op_r == OP_MUL) ? (ans_r ^ bns_r) : (ans_r ^ bds_r);
        // denominator product ad*bd for add/sub/mul kept in d after combine
        d_r <= MW'(ad_r) * MW'(bd_r);
        ds_r <= ads_r ^ bds_r;
      end
      S_MUL2: begin
        p2_r <= prod;
        p2s_r <= (op_r == OP_DIV) ? (ads_r ^ bns_r) : (bns_r ^ ads_r);
      end
      S_COMB: begin
        if (op_r == OP_MUL || op_r == OP_DIV) begin
          n_r <= p1_r; ns_r <= p1s_r;
          x_r <= p1_r;
        end else begin
          n_r <= sum_ext;
          x_r <= sum_ext;
          ns_r <= (p1s_r == p2neg) ? p1s_r : ((p1_r >= p2_r) ? p1s_r : p2neg);
        end
        if (op_r == OP_DIV) begin
          d_r <= p2_r; ds_r <= p2s_r;
          y_r <= p2_r;
        end else begin
          y_r <= d_r;
        end
        k_r <= '0;
      end
      S_GCD: begin
        // Binary GCD: strip shared twos and lone twos, subtract odd pairs.
        if (y_r != '0) begin
          if (!x_r[0] && !y_r[0]) begin
            x_r <= x_r >> 1; y_r <= y_r >> 1; k_r <= k_r + 1'b1;
          end else if (!x_r[0]) x_r <= x_r >> 1;
          else if (!y_r[0]) y_r <= y_r >> 1;
          else if (!trial[MW]) begin
            x_r <= y_r; y_r <= sdiff;
          end else y_r <= y_r - x_r;
        end else begin
          g_r <= x_r << k_r;
          q_r <= n_r; rem_r <= '0; cnt_r <= '0;
        end
      end
      S_DIVN, S_DIVD: begin
        rem_r <= dge ? sdiff : rsh[MW-1:0];
        q_r <= {q_r[MW-2:0], dge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(MW - 1)) begin
          cnt_r <= '0;
          if (st_r == S_DIVN) begin
            qn_r <= {q_r[MW-2:0], dge};
            q_r <= d_r; rem_r <= '0;
          end else q_r <= {q_r[MW-2:0], dge};
        end
      end
      S_OUT: begin
        if (!ov_r) begin
          if (d_r == '0) begin
            res_r.result_numerator <= '0;
            res_r.result_denominator <= '0;
            res_r.status <= 1'b1;
          end else if (n_r == '0) begin
            res_r.result_numerator <= '0;
            res_r.result_denominator <= DenW'(1);
            res_r.status <= 1'b0;
          end else begin
            res_r.result_numerator <= (ns_r ^ ds_r) ? NumW'(-qn_r) : NumW'(qn_r);
            res_r.result_denominator <= q_r[DenW-1:0];
            res_r.status <= 1'b0;
          end
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ----- src/rau_checker.sv -----
// Port-level checker, bound into every rational arithmetic unit.
// Depends on rau_pkg and rational_arithmetic_unit_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "rational_arithmetic_unit_assert.svh"
module rau_checker
  import rau_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire rau_in_t  in_data,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire rau_out_t out_data
);
  // An accepted transaction makes the block busy.
  `RAU_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && !in_stall, in_stall)
  // A pending result holds while stalled.
  `RAU_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  // An error result is always 0/0.
  `RAU_ASSERT_IMP(a_err, clk, rst_n, out_valid && out_data.status,
    out_data.result_numerator == '0 && out_data.result_denominator == '0)
  // A good result has a nonzero denominator.
  `RAU_ASSERT_IMP(a_den, clk, rst_n, out_valid && !out_data.status,
    out_data.result_denominator != '0)
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire

// ----- sim/rational_arithmetic_unit_tb.sv -----
// Testbench for the rational arithmetic unit: directed table plus random fractions,
// each checked against a typed row or the rational predictor. Depends on rau_pkg.
`timescale 1ns / 1ps
module rational_arithmetic_unit_tb;
  import rau_pkg::*;

  localparam int LIMIT_CYCLES = 1400000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  rau_in_t in_data;
  logic out_valid;
  logic out_stall;
  rau_out_t out_data;

  rational_arithmetic_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  rau_out_t fraction_q[$];
  int mismatches;
  int cycle_count;
  bit calm;

  // Exact reduced fraction for one transaction.
  function automatic rau_out_t reduce_fraction(rau_in_t x);
    longint an, ad, bn, bd, n, d, g, t, p, q;
    rau_out_t r;
    an = x.a_numerator;
    ad = x.a_denominator;
    bn = x.b_numerator;
    bd = x.b_denominator;
    case (x.opcode)
      OP_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
      OP_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
      OP_MUL: begin n = an * bn; d = ad * bd; end
      default: begin n = an * bd; d = ad * bn; end
    endcase
    r = '0;
    if (d == 0) begin
      r.status = 1'b1;
    end else if (n == 0) begin
      r.result_denominator = DenW'(1);
    end else begin
      p = (n < 0) ? -n : n;
      q = (d < 0) ? -d : d;
      g = p;
      t = q;
      while (t != 0) begin
        longint m;
        m = g % t;
        g = t;
        t = m;
      end
      p = p / g;
      q = q / g;
      if ((n < 0) != (d < 0)) p = -p;
      r.result_numerator = p[NumW-1:0];
      r.result_denominator = q[DenW-1:0];
    end
    return r;
  endfunction

  // Result side: random stall and comparison against the oldest expectation.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < 27);
      if (out_valid && !out_stall) begin
        if (fraction_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result %p", out_data);
        end else begin
          rau_out_t e;
          e = fraction_q.pop_front();
          if (e.result_numerator !== out_data.result_numerator ||
              e.result_denominator !== out_data.result_denominator ||
              e.status !== out_data.status) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: expected %0d/%0d st %0b, got %0d/%0d st %0b",
                       e.result_numerator, e.result_denominator, e.status,
                       out_data.result_numerator, out_data.result_denominator,
                       out_data.status);
          end
        end
      end
    end
  end

  // Directed rows; checked rows carry a typed expectation.
  typedef struct {
    rau_in_t stim;
    bit typed;
    rau_out_t want;
  } row_t;
  row_t rows[$];

  function automatic rau_in_t mk(logic [1:0] op, int an, int ad, int bn, int bd);
    rau_in_t x;
    x.opcode = op;
    x.a_numerator = an[15:0];
    x.a_denominator = ad[15:0];
    x.b_numerator = bn[15:0];
    x.b_denominator = bd[15:0];
    return x;
  endfunction

  function automatic rau_out_t res(longint n, longint d, bit st);
    rau_out_t r;
    r.result_numerator = n[NumW-1:0];
    r.result_denominator = d[DenW-1:0];
    r.status = st;
    return r;
  endfunction

  function automatic logic [15:0] rand_operand(bit nz);
    logic [15:0] v;
    case ($urandom_range(3))
      0: v = 16'($urandom_range(9));
      1: v = 16'(16'hffff - $urandom_range(9));
      2: v = ($urandom_range(1)) ? 16'(16'h8000 + $urandom_range(3)) :
                                   16'(16'h7fff - $urandom_range(3));
      default: v = 16'($urandom);
    endcase
    if (nz && v == 0) v = 1;
    return v;
  endfunction

  // Drive one transaction and hold it until accepted.
  task automatic send(rau_in_t x, rau_out_t e);
    while (!calm && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fraction_q.push_back(e);
  endtask

  initial begin
    rau_in_t x;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    calm = 1'b0;
    rows.push_back('{mk(OP_ADD, 1, 2, 1, 3), 0, '0});
    rows.push_back('{mk(OP_SUB, 1, 2, 1, 3), 0, '0});
    rows.push_back('{mk(OP_MUL, 2, 3, 3, 4), 0, '0});
    rows.push_back('{mk(OP_DIV, 2, 3, 3, 4), 0, '0});
    rows.push_back('{mk(OP_ADD, 5, 0, 1, 1), 1, res(0, 0, 1)});
    rows.push_back('{mk(OP_MUL, 1, 1, 1, 0), 1, res(0, 0, 1)});
    rows.push_back('{mk(OP_DIV, 3, 4, 0, 7), 1, res(0, 0, 1)});
    rows.push_back('{mk(OP_MUL, 0, 5, 3, 7), 1, res(0, 1, 0)});
    rows.push_back('{mk(OP_SUB, 3, 4, 3, 4), 1, res(0, 1, 0)});
    rows.push_back('{mk(OP_MUL, 1, -2, 1, 1), 1, res(-1, 2, 0)});
    rows.push_back('{mk(OP_DIV, -1, -3, -1, 3), 1, res(-1, 1, 0)});
    rows.push_back('{mk(OP_ADD, -32768, 1, -32768, 1), 1, res(-65536, 1, 0)});
    rows.push_back('{mk(OP_ADD, -32768, -32768, -32768, -32768), 1, res(2, 1, 0)});
    rows.push_back('{mk(OP_MUL, -32768, 1, -32768, 1), 1, res(1073741824, 1, 0)});
    rows.push_back('{mk(OP_MUL, 1, -32768, 1, -32768), 1, res(1, 1073741824, 0)});
    rows.push_back('{mk(OP_ADD, -32768, 32767, -32768, 32767), 0, '0});
    rows.push_back('{mk(OP_SUB, 32767, -32768, -32768, 32767), 0, '0});
    rows.push_back('{mk(OP_DIV, 32767, -32768, -32768, 32767), 0, '0});
    rows.push_back('{mk(OP_ADD, 32767, 32767, 32767, 32767), 1, res(2, 1, 0)});
    rows.push_back('{mk(OP_DIV, -1, -1, -1, -1), 1, res(1, 1, 0)});
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i])
      send(rows[i].stim, rows[i].typed ? rows[i].want : reduce_fraction(rows[i].stim));
    in_valid <= 1'b0;
    // Hold off until every expected result has come.
    while (fraction_q.size() != 0) @(posedge clk);
    for (int k = 0; k < 1400; k++) begin
      calm = (k >= 600 && k < 700);
      x.opcode = 2'($urandom_range(3));
      x.a_numerator = rand_operand(0);
      x.b_numerator = rand_operand(x.opcode == OP_DIV && $urandom_range(9) != 0);
      x.a_denominator = rand_operand($urandom_range(19) != 0);
      x.b_denominator = rand_operand($urandom_range(19) != 0);
      send(x, reduce_fraction(x));
    end
    in_valid <= 1'b0;
    calm = 1'b0;
    while (fraction_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && fraction_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog on total run length.
  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+src
src/rau_pkg.sv
src/rational_arithmetic_unit.sv
src/rau_checker.sv
sim/rational_arithmetic_unit_tb.sv
